[hdl/beeper_pattern_sequencer_core_macros.svh]
// ----------------------------------------------------------------------------
// beeper pattern sequencer assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BEEPER_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define BEEPER_PATTERN_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define BPS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define BPS_ASSERT(lbl, ck, rs, prop, msg)
`define BPS_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

[hdl/bps_pkg.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer package
// beat types, command codes and counter limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bps_pkg;

  localparam int unsigned TICK_W   = 17;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned REP_W    = 8;
  localparam int unsigned PHASE_W  = 8;

  localparam logic [PHASE_W-1:0] SHORT_PERIOD = PHASE_W'(30);
  localparam logic [PHASE_W-1:0] LONG_PERIOD  = PHASE_W'(150);
  localparam logic [TICK_W-1:0]  TICK_MAX     = {TICK_W{1'b1}};
  localparam logic [REP_W-1:0]   DONE_MAX     = {REP_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_HOLD  = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             pattern_long;
    logic [DUR_W-1:0] duration_ticks;
    logic [REP_W-1:0] repeat_count;
  } in_item_t;

  typedef struct packed {
    logic beep_level;
    logic pattern_running;
  } out_item_t;

endpackage

[hdl/bps_in_reg.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer input register
// holds one input beat until the update stage takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bps_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              held_valid,
  output bps_pkg::in_item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule

[hdl/bps_core.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer state update
// pattern counters and drive level, one beat per cycle while step is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "beeper_pattern_sequencer_core_macros.svh"

module bps_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bps_pkg::in_item_t  item,
  input  logic               enabled,
  output bps_pkg::out_item_t result
);

  logic                        drive_level, drive_level_next;
  logic                        long_mode, long_mode_next;
  logic [bps_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  logic [bps_pkg::PHASE_W-1:0] phase, phase_next;
  logic [bps_pkg::DUR_W-1:0]   burst_remaining, burst_remaining_next;
  logic [bps_pkg::DUR_W-1:0]   burst_reload, burst_reload_next;
  logic [bps_pkg::REP_W-1:0]   repeats_wanted, repeats_wanted_next;
  logic [bps_pkg::REP_W-1:0]   repeats_done, repeats_done_next;

  logic                        running;
  logic [bps_pkg::PHASE_W-1:0] period_last;
  logic [bps_pkg::TICK_W-1:0]  tick_inc;
  logic [bps_pkg::PHASE_W-1:0] phase_inc;
  logic [bps_pkg::REP_W-1:0]   done_inc;

  assign running     = (repeats_wanted != '0) && (burst_remaining != '0);
  assign period_last = long_mode ? bps_pkg::LONG_PERIOD - 1'b1
                                 : bps_pkg::SHORT_PERIOD - 1'b1;

  always_comb begin
    tick_inc  = tick_count;
    phase_inc = phase;
    if (tick_count != bps_pkg::TICK_MAX) begin
      tick_inc  = tick_count + 1'b1;
      phase_inc = (phase == period_last) ? '0 : phase + 1'b1;
    end
    done_inc = (repeats_done != bps_pkg::DONE_MAX) ? repeats_done + 1'b1 : repeats_done;
  end

  always_comb begin
    drive_level_next     = drive_level;
    long_mode_next       = long_mode;
    tick_count_next      = tick_count;
    phase_next           = phase;
    burst_remaining_next = burst_remaining;
    burst_reload_next    = burst_reload;
    repeats_wanted_next  = repeats_wanted;
    repeats_done_next    = repeats_done;
    case (item.kind)
      bps_pkg::KIND_TICK: begin
        if (running) begin
          // level flips on each period boundary
          if (phase == '0) begin
            drive_level_next = !drive_level;
          end
          tick_count_next = tick_inc;
          phase_next      = phase_inc;
          if (tick_inc > {1'b0, burst_remaining}) begin
            tick_count_next      = '0;
            phase_next           = '0;
            burst_remaining_next = '0;
            drive_level_next     = 1'b0;
            repeats_done_next    = done_inc;
            if (done_inc >= repeats_wanted) begin
              repeats_done_next   = '0;
              repeats_wanted_next = '0;
            end else begin
              burst_remaining_next = burst_reload;
            end
          end
        end
      end
      bps_pkg::KIND_START: begin
        if (enabled) begin
          long_mode_next       = item.pattern_long;
          burst_remaining_next = item.duration_ticks;
          burst_reload_next    = item.duration_ticks;
          repeats_wanted_next  = item.repeat_count;
          tick_count_next      = '0;
          phase_next           = '0;
        end
      end
      bps_pkg::KIND_HOLD: begin
        if (enabled) begin
          burst_remaining_next = '0;
          tick_count_next      = '0;
          phase_next           = '0;
          drive_level_next     = 1'b1;
        end
      end
      bps_pkg::KIND_STOP: begin
        if (enabled) begin
          burst_remaining_next = '0;
          tick_count_next      = '0;
          phase_next           = '0;
          drive_level_next     = 1'b0;
        end
      end
      default: begin
        drive_level_next = drive_level;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level     <= 1'b0;
      long_mode       <= 1'b0;
      tick_count      <= '0;
      phase           <= '0;
      burst_remaining <= '0;
      burst_reload    <= '0;
      repeats_wanted  <= '0;
      repeats_done    <= '0;
    end else if (step) begin
      drive_level     <= drive_level_next;
      long_mode       <= long_mode_next;
      tick_count      <= tick_count_next;
      phase           <= phase_next;
      burst_remaining <= burst_remaining_next;
      burst_reload    <= burst_reload_next;
      repeats_wanted  <= repeats_wanted_next;
      repeats_done    <= repeats_done_next;
    end
  end

  assign result.beep_level      = drive_level_next;
  assign result.pattern_running = (repeats_wanted_next != '0) &&
                                  (burst_remaining_next != '0);

  `BPS_ASSERT(a_tick_in_burst, clk, rst, running |-> (tick_count <= {1'b0, burst_remaining}), "tick count beyond burst length")
  `BPS_ASSERT(a_phase_range, clk, rst, (phase <= period_last), "phase beyond toggle period")
  `BPS_ASSERT(a_stop_silences, clk, rst, (step && enabled && item.kind == bps_pkg::KIND_STOP) |=> !drive_level, "stop left beeper sounding")

endmodule

[hdl/beeper_pattern_sequencer_core.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer
// beeper drive level from 10 ms ticks and hold, stop and pattern commands
// ----------------------------------------------------------------------------
// Takes one beat per clock: a beat is registered on entry, the pattern state
// is updated from it once the output register can take its result, and that
// result lands in the output register at the same edge, so every beat gives
// exactly one result; a new beat can enter each cycle while results are taken.
// The one register beeper_enabled (reset 1) masks commands, never ticks, and is
// written through cfg_we/cfg_wdata, by the user only while no beat is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module beeper_pattern_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bps_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic               beeper_enabled;
  logic               held_valid;
  bps_pkg::in_item_t  held_item;
  logic               step;
  bps_pkg::out_item_t result;

  assign step = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      beeper_enabled <= 1'b1;
    end else if (cfg_we) begin
      beeper_enabled <= cfg_wdata;
    end
  end

  bps_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  bps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (held_item),
    .enabled (beeper_enabled),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

[tb/bps_beep_checker.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer beat checker
// watches both channels and the enable register, predicts each result beat
// from the accepted input beats and compares them field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bps_beep_checker
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int unsigned fail_count,
  output int unsigned beats_waiting
);

  localparam int unsigned SHORT_TOGGLE = 30;
  localparam int unsigned LONG_TOGGLE  = 150;
  localparam logic [16:0] TICK_CEIL    = 17'h1ffff;
  localparam logic [7:0]  DONE_CEIL    = 8'hff;

  logic        beeper_on;
  logic        level_q;
  logic        long_q;
  logic [16:0] tick_cnt;
  logic [15:0] burst_left;
  logic [15:0] burst_len;
  logic [7:0]  reps_wanted;
  logic [7:0]  reps_done;

  out_item_t   expected_beeps[$];
  out_item_t   want_beep;
  int unsigned err_cnt = 0;

  function automatic out_item_t predict_beep(in_item_t b);
    out_item_t   r;
    int unsigned period;
    if (b.kind == KIND_TICK) begin
      if (reps_wanted != 0 && burst_left != 0) begin
        period = long_q ? LONG_TOGGLE : SHORT_TOGGLE;
        if ((tick_cnt % period) == 0) level_q = ~level_q;
        if (tick_cnt < TICK_CEIL) tick_cnt = tick_cnt + 17'd1;
        // burst over: silence, count it, reload or finish
        if (tick_cnt > {1'b0, burst_left}) begin
          tick_cnt   = '0;
          burst_left = '0;
          level_q    = 1'b0;
          if (reps_done < DONE_CEIL) reps_done = reps_done + 8'd1;
          if (reps_done >= reps_wanted) begin
            reps_done   = '0;
            reps_wanted = '0;
          end else begin
            burst_left = burst_len;
          end
        end
      end
    end else if (beeper_on) begin
      burst_left = '0;
      case (b.kind)
        KIND_HOLD: begin
          level_q = 1'b1;
        end
        KIND_STOP: begin
          level_q = 1'b0;
        end
        default: begin
          long_q      = b.pattern_long;
          burst_left  = b.duration_ticks;
          burst_len   = b.duration_ticks;
          reps_wanted = b.repeat_count;
        end
      endcase
      tick_cnt = '0;
    end
    r.beep_level      = level_q;
    r.pattern_running = (reps_wanted != 0) && (burst_left != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      beeper_on   = 1'b1;
      level_q     = 1'b0;
      long_q      = 1'b0;
      tick_cnt    = '0;
      burst_left  = '0;
      burst_len   = '0;
      reps_wanted = '0;
      reps_done   = '0;
      expected_beeps.delete();
    end else begin
      if (cfg_we) beeper_on = cfg_wdata;
      if (in_valid && in_ready) expected_beeps.push_back(predict_beep(in_data));
      if (out_valid && out_ready) begin
        if (expected_beeps.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got level %b running %b",
                   $time, out_data.beep_level, out_data.pattern_running);
          err_cnt++;
        end else begin
          want_beep = expected_beeps.pop_front();
          if (out_data.beep_level !== want_beep.beep_level) begin
            $display("%0t: beep_level expected %b got %b",
                     $time, want_beep.beep_level, out_data.beep_level);
            err_cnt++;
          end
          if (out_data.pattern_running !== want_beep.pattern_running) begin
            $display("%0t: pattern_running expected %b got %b",
                     $time, want_beep.pattern_running, out_data.pattern_running);
            err_cnt++;
          end
        end
      end
    end
    fail_count    <= err_cnt;
    beats_waiting <= expected_beeps.size();
  end

endmodule

[tb/tb_beeper_pattern_sequencer_core.sv]
// ----------------------------------------------------------------------------
// beeper pattern sequencer testbench
// directed hold, stop and pattern beats, then random pattern runs with ticks
// and stray commands across enable settings, bursty sender, stalling receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_beeper_pattern_sequencer_core;
  import bps_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;

  int unsigned fail_count;
  int unsigned beats_waiting;
  int unsigned tx_burst    = 0;
  int unsigned beats_taken = 0;
  logic        enabled_now = 1'b1;

  always #5 clk = ~clk;

  beeper_pattern_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bps_beep_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .beats_waiting (beats_waiting)
  );

  function automatic in_item_t beat_of(kind_t k, logic pl, logic [15:0] d, logic [7:0] r);
    in_item_t b;
    b.kind           = k;
    b.pattern_long   = pl;
    b.duration_ticks = d;
    b.repeat_count   = r;
    return b;
  endfunction

  function automatic in_item_t tick_beat();
    return beat_of(KIND_TICK, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
  endfunction

  function automatic in_item_t stray_beat();
    return beat_of(kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endfunction

  // bursts of back-to-back beats with random gaps in between
  task automatic send_beat(input in_item_t b);
    int unsigned gap;
    if (tx_burst == 0) begin
      tx_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      gap      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (!in_ready);
    tx_burst--;
    if (b.kind == KIND_TICK || enabled_now) beats_taken++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    tx_burst = 0;
    do @(posedge clk); while (beats_waiting != 0);
  endtask

  task automatic write_enable(input logic v);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we      = 1'b0;
    enabled_now = v;
  endtask

  // one start followed by ticks to play it out (capped), with stray commands, or stray commands alone
  task automatic run_pattern_seq;
    int unsigned style;
    int unsigned dur;
    int unsigned reps;
    int unsigned ticks;
    logic        pl;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(5, 20)) send_beat(stray_beat());
    end else begin
      pl    = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 9);
      if (style == 0)
        dur = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535);
      else if (style < 7)
        dur = pl ? $urandom_range(100, 320) : $urandom_range(1, 75);
      else
        dur = $urandom_range(1, 8);
      style = $urandom_range(0, 9);
      if (style == 0)      reps = $urandom_range(0, 255);
      else if (style < 7)  reps = $urandom_range(1, 3);
      else                 reps = $urandom_range(4, 8);
      send_beat(beat_of(KIND_START, pl, 16'(dur), 8'(reps)));
      ticks = (dur + 1) * reps + $urandom_range(0, 4);
      if (ticks > 360) ticks = $urandom_range(20, 360);
      repeat (ticks) begin
        if ($urandom_range(0, 79) == 0) send_beat(stray_beat());
        else                            send_beat(tick_beat());
      end
      if ($urandom_range(0, 5) == 0)
        send_beat(beat_of(($urandom_range(0, 1) == 0) ? KIND_HOLD : KIND_STOP,
                          1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255))));
    end
  endtask

  // receiver: ready runs, choppy runs and blocked runs
  initial begin
    int unsigned span;
    int unsigned style;
    span  = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        style = $urandom_range(0, 2);
        span  = (style == 2) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      end
      span--;
      case (style)
        0: begin
          out_ready = 1'b1;
        end
        1: begin
          out_ready = ($urandom_range(0, 2) != 0);
        end
        default: begin
          out_ready = 1'b0;
        end
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic        phase_en  [5];
    int unsigned phase_len [5];
    int unsigned target;
    phase_en  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_len = '{700, 200, 600, 100, 100};
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_beat(tick_beat());
    send_beat(beat_of(KIND_HOLD, 1'b0, 16'h0000, 8'h00));
    send_beat(tick_beat());
    send_beat(beat_of(KIND_STOP, 1'b1, 16'hffff, 8'hff));
    send_beat(beat_of(KIND_START, 1'b0, 16'd0, 8'd3));
    send_beat(beat_of(KIND_START, 1'b0, 16'd5, 8'd0));
    send_beat(beat_of(KIND_START, 1'b0, 16'd2, 8'd2));
    repeat (6) send_beat(tick_beat());
    // interrupted run leaves its completed bursts counted
    send_beat(beat_of(KIND_START, 1'b0, 16'd3, 8'd3));
    repeat (4) send_beat(tick_beat());
    send_beat(beat_of(KIND_HOLD, 1'b1, 16'h1234, 8'h56));
    send_beat(beat_of(KIND_START, 1'b1, 16'hffff, 8'hff));
    repeat (2) send_beat(tick_beat());
    send_beat(beat_of(KIND_STOP, 1'b0, 16'h0000, 8'h00));
    send_beat(beat_of(KIND_START, 1'b0, 16'd1, 8'd2));
    repeat (2) send_beat(tick_beat());

    for (int p = 0; p < 5; p++) begin
      write_enable(phase_en[p]);
      target = beats_taken + phase_len[p];
      while (beats_taken < target) run_pattern_seq();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && beats_waiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[beeper_pattern_sequencer_core.f]
+incdir+hdl
hdl/bps_pkg.sv
hdl/bps_in_reg.sv
hdl/bps_core.sv
hdl/beeper_pattern_sequencer_core.sv
tb/bps_beep_checker.sv
tb/tb_beeper_pattern_sequencer_core.sv
